FILE: rtl/mrfd_pkg.sv
// shared types and constants for the motor record frame deframer
`timescale 1ns / 1ps

package mrfd_pkg;

  // framing constants
  localparam logic [7:0] HEADER_BYTE  = 8'hFF;
  localparam logic [7:0] RECORD_BYTES = 8'd4;

  // parser phase codes
  localparam logic [2:0] PH_HUNT  = 3'd0;
  localparam logic [2:0] PH_LEN   = 3'd1;
  localparam logic [2:0] PH_BODY  = 3'd2;
  localparam logic [2:0] PH_FOOT1 = 3'd3;
  localparam logic [2:0] PH_FOOT2 = 3'd4;

  // result kind codes
  localparam logic [1:0] KIND_RECORD   = 2'd0;
  localparam logic [1:0] KIND_GOOD     = 2'd1;
  localparam logic [1:0] KIND_HDR_ERR  = 2'd2;
  localparam logic [1:0] KIND_FOOT_ERR = 2'd3;

  // compact result as it sits in the queue
  typedef struct packed {
    logic [1:0]  kind;
    logic [23:0] hold;
    logic [7:0]  last_byte;
  } q_entry_t;

  // front to queue
  typedef struct packed {
    logic     push;
    q_entry_t entry;
  } q_push_t;

  // queue to back
  typedef struct packed {
    logic     full;
    logic     empty;
    q_entry_t head;
  } q_stat_t;

endpackage

FILE: rtl/mrfd_ifs.sv
// valid/ready channel interfaces for received bytes and result items
`timescale 1ns / 1ps

interface mrfd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mrfd_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  motor_id;
  logic [7:0]  item_id;
  logic [15:0] value;

  modport source (output valid, output kind, output motor_id, output item_id,
                  output value, input ready);
  modport sink   (input valid, input kind, input motor_id, input item_id,
                  input value, output ready);
endinterface

FILE: rtl/motor_record_frame_deframer.sv
// Motor record frame deframer: header/length/record/footer byte parser.
// Throughput: one received byte per cycle; the parser takes a byte whenever the
//   result queue has a free entry; the output register drains one per cycle
//   while out_ready is high. The completing byte writes a result into the queue,
//   and the output register loads it once that register is empty or draining.
// Reset (rst_n low, synchronous): parser back to header hunting, queue and
//   output register emptied.
`timescale 1ns / 1ps

module motor_record_frame_deframer
  import mrfd_pkg::*;
#(
  parameter int QDEPTH = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  mrfd_byte_if.sink     in_bus,
  mrfd_result_if.source out_bus
);

  q_push_t q_push;
  q_stat_t q_stat;
  logic    pop;

  // byte parser
  mrfd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_bus.valid),
    .q_full   (q_stat.full),
    .in_byte  (in_bus.rx_byte),
    .in_ready (in_bus.ready),
    .q_push   (q_push)
  );

  // result queue
  mrfd_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_push (q_push),
    .pop    (pop),
    .q_stat (q_stat)
  );

  // output stage
  mrfd_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_stat       (q_stat),
    .out_ready    (out_bus.ready),
    .pop          (pop),
    .out_valid    (out_bus.valid),
    .out_kind     (out_bus.kind),
    .out_motor_id (out_bus.motor_id),
    .out_item_id  (out_bus.item_id),
    .out_value    (out_bus.value)
  );

  // parser never produces a result into a full queue
  assert property (@(posedge clk) disable iff (!rst_n)
    q_push.push |-> !q_stat.full)
    else $error("result pushed into full queue");

  // queue cannot read as full and empty at once
  assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.full && q_stat.empty))
    else $error("queue both full and empty");

  // frame status results carry zero record fields
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_bus.valid && out_bus.kind != KIND_RECORD) |->
      (out_bus.motor_id == 8'd0 && out_bus.item_id == 8'd0 && out_bus.value == 16'd0))
    else $error("status result with nonzero record fields");

  // a pop always loads the output register, leaving it valid
  assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> out_bus.valid)
    else $error("output register not loaded after pop");

endmodule

FILE: rtl/mrfd_front.sv
// byte parser: frame state machine that classifies bytes and queues results
`timescale 1ns / 1ps

module mrfd_front
  import mrfd_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  logic    q_full,
  input  logic [7:0] in_byte,
  output logic    in_ready,
  output q_push_t q_push
);

  logic [2:0]  phase_r, phase_nxt;
  logic [7:0]  bytes_left_r, bytes_left_nxt;
  logic [1:0]  bir_r, bir_nxt;
  logic [23:0] hold_r, hold_nxt;
  logic        ffb_r, ffb_nxt;
  logic        accept;

  // take a byte whenever the queue has room for a possible result
  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // next state and result classification
  always_comb begin
    phase_nxt             = phase_r;
    bytes_left_nxt        = bytes_left_r;
    bir_nxt               = bir_r;
    hold_nxt              = hold_r;
    ffb_nxt               = ffb_r;
    q_push.push           = 1'b0;
    q_push.entry.kind     = KIND_RECORD;
    q_push.entry.hold     = hold_r;
    q_push.entry.last_byte = in_byte;
    if (accept) begin
      unique case (phase_r)
        PH_LEN: begin
          bytes_left_nxt = in_byte;
          bir_nxt        = 2'd0;
          hold_nxt       = 24'd0;
          phase_nxt      = (in_byte == 8'd0) ? PH_FOOT1 : PH_BODY;
        end
        PH_BODY: begin
          if (bir_r == 2'd0 && bytes_left_r < RECORD_BYTES) begin
            // trailing byte that cannot complete a record
          end else if (bir_r == 2'd3) begin
            q_push.push       = 1'b1;
            q_push.entry.kind = KIND_RECORD;
            hold_nxt          = 24'd0;
            bir_nxt           = 2'd0;
          end else begin
            hold_nxt = {hold_r[15:0], in_byte};
            bir_nxt  = bir_r + 2'd1;
          end
          bytes_left_nxt = bytes_left_r - 8'd1;
          if (bytes_left_r == 8'd1) begin
            phase_nxt = PH_FOOT1;
          end
        end
        PH_FOOT1: begin
          ffb_nxt   = (in_byte != 8'd0);
          phase_nxt = PH_FOOT2;
        end
        PH_FOOT2: begin
          q_push.push       = 1'b1;
          q_push.entry.kind = (ffb_r || in_byte != 8'd0) ? KIND_FOOT_ERR : KIND_GOOD;
          ffb_nxt           = 1'b0;
          bir_nxt           = 2'd0;
          hold_nxt          = 24'd0;
          phase_nxt         = PH_HUNT;
        end
        default: begin
          // hunting, and any unused phase code
          if (in_byte == HEADER_BYTE) begin
            phase_nxt = PH_LEN;
          end else begin
            q_push.push       = 1'b1;
            q_push.entry.kind = KIND_HDR_ERR;
            phase_nxt         = PH_HUNT;
          end
        end
      endcase
    end
  end

  // parser state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HUNT;
      bytes_left_r <= 8'd0;
      bir_r        <= 2'd0;
      hold_r       <= 24'd0;
      ffb_r        <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      bytes_left_r <= bytes_left_nxt;
      bir_r        <= bir_nxt;
      hold_r       <= hold_nxt;
      ffb_r        <= ffb_nxt;
    end
  end

endmodule

FILE: rtl/mrfd_queue.sv
// short result queue between parser and output stage
`timescale 1ns / 1ps

module mrfd_queue
  import mrfd_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic    clk,
  input  logic    rst_n,
  input  q_push_t q_push,
  input  logic    pop,
  output q_stat_t q_stat
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  q_entry_t      mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_push, do_pop;

  assign q_stat.full  = (count_r == FULL_CNT);
  assign q_stat.empty = (count_r == '0);
  assign q_stat.head  = mem_r[rd_ptr_r];

  assign do_push = q_push.push && !q_stat.full;
  assign do_pop  = pop && !q_stat.empty;

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= q_push.entry;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST) ? '0 : wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST) ? '0 : rd_ptr_r + PW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CW'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

endmodule

FILE: rtl/mrfd_back.sv
// output stage: expands queued entries into result fields, registered
`timescale 1ns / 1ps

module mrfd_back
  import mrfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  q_stat_t     q_stat,
  input  logic        out_ready,
  output logic        pop,
  output logic        out_valid,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_motor_id,
  output logic [7:0]  out_item_id,
  output logic [15:0] out_value
);

  logic        valid_r;
  logic [1:0]  kind_r;
  logic [7:0]  motor_r, item_r;
  logic [15:0] value_r;
  logic        is_rec;

  // load when the register is empty or its item leaves this cycle
  assign pop    = !q_stat.empty && (!valid_r || out_ready);
  assign is_rec = (q_stat.head.kind == KIND_RECORD);

  // output valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (pop) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  // output payload, fields zero for frame status kinds
  always_ff @(posedge clk) begin
    if (pop) begin
      kind_r  <= q_stat.head.kind;
      motor_r <= is_rec ? q_stat.head.hold[23:16] : 8'd0;
      item_r  <= is_rec ? q_stat.head.hold[15:8]  : 8'd0;
      value_r <= is_rec ? {q_stat.head.hold[7:0], q_stat.head.last_byte} : 16'd0;
    end
  end

  assign out_valid    = valid_r;
  assign out_kind     = kind_r;
  assign out_motor_id = motor_r;
  assign out_item_id  = item_r;
  assign out_value    = value_r;

endmodule
